// ===== src/wcu_pkg.sv =====
`default_nettype none

package wcu_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int SHORT_LAG    = 1;
    localparam int MID_LAG      = 11;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int DATA_W = 32;
    localparam int PCT_W  = 7;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [DATA_W-1:0] t_word;
    typedef logic [PCT_W-1:0]  t_pct;

    localparam t_slot SLOT_LAST = t_slot'(WINDOW_DEPTH - 1);
    localparam t_slot SLOT_SPAN = t_slot'(WINDOW_DEPTH);
    localparam t_slot SHORT_OFF = t_slot'(SHORT_LAG % WINDOW_DEPTH);
    localparam t_slot MID_OFF   = t_slot'(MID_LAG % WINDOW_DEPTH);

    localparam t_pct PCT_MAX   = t_pct'(100);
    localparam t_pct PCT_SCALE = t_pct'(100);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

    typedef struct packed {
        t_word user_time;
        t_word nice_time;
        t_word system_time;
        t_word idle_time;
        t_word iowait_time;
        t_word hardirq_time;
        t_word softirq_time;
        t_word steal_time;
        t_word guest_time;
    } t_in_req;

    typedef struct packed {
        t_pct instant_percent;
        t_pct short_percent;
        t_pct mid_percent;
        t_pct window_percent;
    } t_out_req;

    typedef struct packed {
        t_word total;
        t_word idle;
    } t_entry;

    typedef enum logic [1:0] {
        SEL_NEW   = 2'd0,
        SEL_SHORT = 2'd1,
        SEL_MID   = 2'd2,
        SEL_OLD   = 2'd3
    } t_sel;

    typedef struct packed {
        logic load;
        logic rd_en;
        t_sel rd_sel;
        logic prep;
        t_sel rate_sel;
        logic div_start;
        logic div_second;
        logic cap_first;
        logic fin;
        logic ring_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic zero_all;
        logic carry;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic t_slot slot_back(input t_slot n, input t_slot off);
        if (n >= off) begin
            return n - off;
        end else begin
            return n + (SLOT_SPAN - off);
        end
    endfunction

    function automatic t_slot slot_next(input t_slot n);
        if (n == SLOT_LAST) begin
            return '0;
        end else begin
            return n + t_slot'(1);
        end
    endfunction

    function automatic t_pct pct_clamp(input t_word q);
        if (q >= t_word'(PCT_MAX)) begin
            return PCT_MAX;
        end else begin
            return q[PCT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/wcu_ring.sv =====
`default_nettype none

module wcu_ring
    import wcu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_we,
    input  wire t_slot  i_waddr,
    input  wire t_entry i_wdata,
    input  wire t_slot  i_raddr,
    output t_entry      o_rdata
);

    t_entry                  r_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    t_entry                  r_rdata;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_raddr];
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== src/wcu_div.sv =====
`default_nettype none

module wcu_div
    import wcu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_word i_dividend,
    input  wire t_word i_divisor,
    output logic       o_done,
    output t_word      o_quo,
    output t_word      o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_quo;
    t_word            r_rem;
    t_word            r_dvs;
    logic [DATA_W:0]  w_trial;

    assign w_trial = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("division started while busy");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_dvs))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ===== src/wcu_datapath.sv =====
`default_nettype none

module wcu_datapath
    import wcu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    output t_sts         o_sts,
    input  wire t_in_req i_in_req,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_out_req     o_out_req
);

    t_word  r_part0, r_part1, r_part2, r_idle_in;
    t_slot  r_newest;
    logic   r_cap_pend;
    t_sel   r_cap_sel;
    t_entry r_new, r_short, r_mid, r_old;
    t_word  r_all, r_busy;
    t_word  r_q0, r_sum;
    logic   r_carry, r_half;
    t_pct   r_pct_inst, r_pct_short, r_pct_mid, r_pct_win;
    logic   r_out_valid;
    t_out_req r_out;

    t_slot  w_short_slot, w_mid_slot, w_oldest, w_raddr;
    t_entry w_rdata, w_oth, w_wdata;
    t_word  w_all, w_idl, w_x;
    logic [DATA_W+PCT_W-1:0] w_prod;
    logic   w_div_done;
    t_word  w_div_quo, w_div_rem, w_dividend;
    logic [DATA_W:0] w_sum;
    t_pct   w_pct;

    assign w_short_slot = slot_back(r_newest, SHORT_OFF);
    assign w_mid_slot   = slot_back(r_newest, MID_OFF);
    assign w_oldest     = slot_next(r_newest);

    always_comb begin
        case (i_cmd.rd_sel)
            SEL_NEW:   w_raddr = r_newest;
            SEL_SHORT: w_raddr = w_short_slot;
            SEL_MID:   w_raddr = w_mid_slot;
            SEL_OLD:   w_raddr = w_oldest;
            default:   w_raddr = r_newest;
        endcase
    end

    assign w_wdata.total = r_part0 + r_part1 + r_part2;
    assign w_wdata.idle  = r_idle_in;

    wcu_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cmd.ring_write),
        .i_waddr (w_oldest),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_part0   <= i_in_req.user_time + i_in_req.nice_time + i_in_req.system_time;
            r_part1   <= i_in_req.idle_time + i_in_req.iowait_time + i_in_req.hardirq_time;
            r_part2   <= i_in_req.softirq_time + i_in_req.steal_time + i_in_req.guest_time;
            r_idle_in <= i_in_req.idle_time;
        end
        r_cap_sel <= i_cmd.rd_sel;
        if (r_cap_pend) begin
            case (r_cap_sel)
                SEL_NEW:   r_new   <= w_rdata;
                SEL_SHORT: r_short <= w_rdata;
                SEL_MID:   r_mid   <= w_rdata;
                SEL_OLD:   r_old   <= w_rdata;
                default:   r_new   <= w_rdata;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.rate_sel)
            SEL_SHORT: w_oth = r_short;
            SEL_MID:   w_oth = r_mid;
            SEL_OLD:   w_oth = r_old;
            default:   w_oth = '0;
        endcase
    end

    assign w_all  = r_new.total - w_oth.total;
    assign w_idl  = r_new.idle - w_oth.idle;
    assign w_x    = w_all - w_idl;
    assign w_prod = w_x * PCT_SCALE;

    assign w_dividend = i_cmd.div_second ? r_sum : r_busy;

    wcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_all),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    assign w_sum = {1'b0, r_busy} + {1'b0, w_div_rem};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_all  <= w_all;
            r_busy <= w_prod[DATA_W-1:0];
        end
        if (i_cmd.cap_first && w_div_done) begin
            r_q0    <= w_div_quo;
            r_sum   <= w_sum[DATA_W-1:0];
            r_carry <= w_sum[DATA_W];
            r_half  <= ({w_div_rem, 1'b0} >= {1'b0, r_all});
        end
    end

    always_comb begin
        if (r_all == '0) begin
            w_pct = '0;
        end else if (r_carry) begin
            w_pct = pct_clamp(w_div_quo);
        end else if (r_q0 >= t_word'(PCT_MAX)) begin
            w_pct = PCT_MAX;
        end else begin
            w_pct = r_q0[PCT_W-1:0] + t_pct'(r_half);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            case (i_cmd.rate_sel)
                SEL_NEW:   r_pct_inst  <= w_pct;
                SEL_SHORT: r_pct_short <= w_pct;
                SEL_MID:   r_pct_mid   <= w_pct;
                SEL_OLD:   r_pct_win   <= w_pct;
                default:   r_pct_inst  <= w_pct;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.instant_percent <= r_pct_inst;
            r_out.short_percent   <= r_pct_short;
            r_out.mid_percent     <= r_pct_mid;
            r_out.window_percent  <= r_pct_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest    <= SLOT_LAST;
            r_cap_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_pend <= i_cmd.rd_en;
            if (i_cmd.ring_write) begin
                r_newest <= w_oldest;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.zero_all = (r_all == '0);
    assign o_sts.carry    = r_carry;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out.instant_percent <= PCT_MAX && r_out.short_percent <= PCT_MAX
            && r_out.mid_percent <= PCT_MAX && r_out.window_percent <= PCT_MAX))
        else $error("percentage above full scale");

endmodule

`default_nettype wire

// ===== src/wcu_ctrl.sv =====
`default_nettype none

module wcu_ctrl
    import wcu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_RD_NEW   = 14'h0002,
        S_RD_SHORT = 14'h0004,
        S_RD_MID   = 14'h0008,
        S_RD_OLD   = 14'h0010,
        S_CAP      = 14'h0020,
        S_PREP     = 14'h0040,
        S_DIV1     = 14'h0080,
        S_WAIT1    = 14'h0100,
        S_CHK      = 14'h0200,
        S_WAIT2    = 14'h0400,
        S_FIN      = 14'h0800,
        S_WRITE    = 14'h1000,
        S_OUT      = 14'h2000
    } t_state;

    t_state r_state, n_state;
    t_sel   r_rate, n_rate;

    always_comb begin
        n_state = r_state;
        n_rate  = r_rate;
        o_cmd   = '0;
        o_cmd.rd_sel   = SEL_NEW;
        o_cmd.rate_sel = r_rate;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_NEW;
                end
            end
            S_RD_NEW: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD_SHORT;
            end
            S_RD_SHORT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_SHORT;
                n_state      = S_RD_MID;
            end
            S_RD_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_MID;
                n_state      = S_RD_OLD;
            end
            S_RD_OLD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_OLD;
                n_state      = S_CAP;
            end
            S_CAP: begin
                n_rate  = SEL_NEW;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.zero_all) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_WAIT1;
                end
            end
            S_WAIT1: begin
                o_cmd.cap_first = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.carry) begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_second = 1'b1;
                    n_state          = S_WAIT2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WAIT2: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                case (r_rate)
                    SEL_NEW:   n_rate = SEL_SHORT;
                    SEL_SHORT: n_rate = SEL_MID;
                    SEL_MID:   n_rate = SEL_OLD;
                    default:   n_rate = SEL_NEW;
                endcase
                n_state = (r_rate == SEL_OLD) ? S_WRITE : S_PREP;
            end
            S_WRITE: begin
                o_cmd.ring_write = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= SEL_NEW;
        end else begin
            r_state <= n_state;
            r_rate  <= n_rate;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_wait_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT1 && !i_sts.div_done) |=> (r_state == S_WAIT1))
        else $error("left division wait early");

    a_last_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_rate == SEL_OLD) |=> (r_state == S_WRITE))
        else $error("window rate did not close the item");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ring_write |=> (r_state == S_OUT && !o_cmd.ring_write))
        else $error("ring written twice for one request");

endmodule

`default_nettype wire

// ===== src/windowed_cpu_utilization.sv =====
// Channel   Direction  Payload     Handshake
// in        input      t_in_req    i_in_valid / o_in_stall
// out       output     t_out_req   o_out_valid / i_out_stall
//
// One request takes four ring reads, then four rates on one
// restoring divider; a rate whose busy plus remainder carries
// takes a second division, and a zero span skips the divider.
// Reset is synchronous; the ring reads as zero until each slot is written.
// A result waits in the output register while the next request is taken.

`default_nettype none

module windowed_cpu_utilization
    import wcu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_req     o_out_req
);

    t_cmd w_cmd;
    t_sts w_sts;

    wcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wcu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

// ===== test/tb_windowed_cpu_utilization.sv =====
`timescale 1ns / 1ps

module tb_windowed_cpu_utilization;
    import wcu_pkg::*;

    localparam int RANDOM_ITEMS   = 1680;
    localparam int STEADY_FROM    = 900;
    localparam int STEADY_TO      = 1200;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_MAX     = 10;
    localparam t_word ONES        = '1;

    localparam t_out_req ALL_IDLE = '0;
    localparam t_out_req ALL_BUSY = {4{PCT_MAX}};

    typedef enum int {
        SEQ_RISING,
        SEQ_WRAPPING,
        SEQ_NOISE,
        SEQ_GLITCHY
    } t_seq_kind;

    typedef struct {
        t_in_req  smp;
        bit       typed;
        t_out_req want;
    } t_dir_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    logic steady   = 1'b0;
    logic hold_out = 1'b0;

    t_out_req rate_due[$];
    t_word    hist_total [WINDOW_DEPTH];
    t_word    hist_idle  [WINDOW_DEPTH];
    t_slot    hist_head;

    int samples_sent = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int zero_spans   = 0;
    int clamps       = 0;
    int carries      = 0;
    int directed_cnt = 0;

    windowed_cpu_utilization dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_req mk_sample(input t_word u, input t_word n, input t_word s,
                                          input t_word idl, input t_word io, input t_word hi,
                                          input t_word si, input t_word st, input t_word g);
        t_in_req smp;
        smp.user_time    = u;
        smp.nice_time    = n;
        smp.system_time  = s;
        smp.idle_time    = idl;
        smp.iowait_time  = io;
        smp.hardirq_time = hi;
        smp.softirq_time = si;
        smp.steal_time   = st;
        smp.guest_time   = g;
        return smp;
    endfunction

    function automatic t_dir_row dir_row(input t_in_req smp, input bit typed,
                                         input t_out_req want);
        t_dir_row row;
        row.smp   = smp;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_pct busy_share(input t_word span, input t_word idle_span);
        t_word           busy;
        t_word           rem;
        t_word           q;
        logic [DATA_W:0] acc;
        if (span == '0) begin
            zero_spans++;
            return '0;
        end
        busy = (span - idle_span) * t_word'(PCT_SCALE);
        rem  = busy % span;
        acc  = {1'b0, busy} + {1'b0, rem};
        if (acc[DATA_W]) begin
            carries++;
        end
        q = acc[DATA_W-1:0] / span;
        if (q > t_word'(PCT_MAX)) begin
            clamps++;
            return PCT_MAX;
        end
        return q[PCT_W-1:0];
    endfunction

    function automatic t_out_req predict_rates(input t_in_req smp);
        t_out_req r;
        int       n;
        int       oldest;
        int       s_slot;
        int       m_slot;
        n      = int'(hist_head);
        oldest = (n + 1) % WINDOW_DEPTH;
        s_slot = (n + WINDOW_DEPTH - SHORT_LAG % WINDOW_DEPTH) % WINDOW_DEPTH;
        m_slot = (n + WINDOW_DEPTH - MID_LAG % WINDOW_DEPTH) % WINDOW_DEPTH;
        r.instant_percent = busy_share(hist_total[n], hist_idle[n]);
        r.short_percent   = busy_share(hist_total[n] - hist_total[s_slot],
                                       hist_idle[n] - hist_idle[s_slot]);
        r.mid_percent     = busy_share(hist_total[n] - hist_total[m_slot],
                                       hist_idle[n] - hist_idle[m_slot]);
        r.window_percent  = busy_share(hist_total[n] - hist_total[oldest],
                                       hist_idle[n] - hist_idle[oldest]);
        hist_total[oldest] = smp.user_time + smp.nice_time + smp.system_time
                           + smp.idle_time + smp.iowait_time + smp.hardirq_time
                           + smp.softirq_time + smp.steal_time + smp.guest_time;
        hist_idle[oldest]  = smp.idle_time;
        hist_head          = t_slot'(oldest);
        return r;
    endfunction

    task automatic offer_sample(input t_in_req smp, input t_out_req want);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 25) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 12);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        rate_due.push_back(want);
        samples_sent++;
    endtask

    task automatic check_field(input string fname, input t_pct want, input t_pct got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, fname, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= hold_out || (!steady && $urandom_range(99) < 25);
    end

    initial begin : out_holdoff
        wait (results_seen >= HOLD_AFTER);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin : rate_check
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (rate_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: rate set %h with nothing pending", $realtime, o_out_req);
                end
            end else begin
                want = rate_due.pop_front();
                check_field("instant_percent", want.instant_percent, o_out_req.instant_percent);
                check_field("short_percent", want.short_percent, o_out_req.short_percent);
                check_field("mid_percent", want.mid_percent, o_out_req.mid_percent);
                check_field("window_percent", want.window_percent, o_out_req.window_percent);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("windowed_cpu_utilization verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_dir_row  rows[$];
        t_word     ctr[9];
        t_seq_kind kind;
        t_out_req  predicted;
        int        seg_left;
        int        step_cap;
        int        pick;

        foreach (hist_total[j]) begin
            hist_total[j] = '0;
            hist_idle[j]  = '0;
        end
        hist_head = SLOT_LAST;

        // fresh ring, then a fully busy newest entry
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(100, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES,
                                         ONES), 1'b1, ALL_BUSY));
        // idle only after a wrapped counter sum
        rows.push_back(dir_row(mk_sample(0, 0, 0, 50, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 50, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        // repeated sample: zero span on the short lag
        rows.push_back(dir_row(mk_sample(0, 0, 0, 50, 0, 0, 0, 0, 0), 1'b1, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(1000, 0, 0, 50, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(1500, 0, 0, 50, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        // idle falls while total rises: rate clamped
        rows.push_back(dir_row(mk_sample(2000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(ONES, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, ONES, 0, 0, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, ONES, 0, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, ONES, 0, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, ONES, 0, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, 0, ONES, 0, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, 0, 0, ONES, 0, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, 0, 0, 0, ONES, 0), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample(0, 0, 0, 0, 0, 0, 0, 0, ONES), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample({16{2'b10}}, {16{2'b10}}, {16{2'b10}}, {16{2'b10}},
                                         {16{2'b10}}, {16{2'b10}}, {16{2'b10}}, {16{2'b10}},
                                         {16{2'b10}}), 1'b0, ALL_IDLE));
        rows.push_back(dir_row(mk_sample({16{2'b01}}, {16{2'b01}}, {16{2'b01}}, {16{2'b01}},
                                         {16{2'b01}}, {16{2'b01}}, {16{2'b01}}, {16{2'b01}},
                                         {16{2'b01}}), 1'b0, ALL_IDLE));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            predicted = predict_rates(rows[r].smp);
            offer_sample(rows[r].smp, rows[r].typed ? rows[r].want : predicted);
        end
        directed_cnt = rows.size();

        foreach (ctr[j]) begin
            ctr[j] = '0;
        end
        seg_left = 0;
        kind     = SEQ_RISING;
        step_cap = 1000;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == STEADY_FROM) begin
                steady <= 1'b1;
            end
            if (k == STEADY_TO) begin
                steady <= 1'b0;
            end
            if (seg_left == 0) begin
                pick     = $urandom_range(99);
                kind     = (pick < 60) ? SEQ_RISING :
                           (pick < 75) ? SEQ_WRAPPING :
                           (pick < 85) ? SEQ_NOISE : SEQ_GLITCHY;
                seg_left = $urandom_range(20, 300);
                case ($urandom_range(2))
                    0: step_cap = 15;
                    1: step_cap = 1000;
                    default: step_cap = 100000;
                endcase
                if (kind == SEQ_WRAPPING) begin
                    foreach (ctr[j]) begin
                        ctr[j] = $urandom | 32'hFFF0_0000;
                    end
                end
            end
            seg_left--;
            if (kind == SEQ_NOISE) begin
                foreach (ctr[j]) begin
                    ctr[j] = $urandom;
                end
            end else begin
                foreach (ctr[j]) begin
                    ctr[j] = ctr[j] + t_word'($urandom_range(0, step_cap));
                end
                if (kind == SEQ_GLITCHY && $urandom_range(9) == 0) begin
                    ctr[$urandom_range(8)] = $urandom;
                end
            end
            begin
                t_in_req smp;
                smp = mk_sample(ctr[0], ctr[1], ctr[2], ctr[3], ctr[4], ctr[5], ctr[6],
                                ctr[7], ctr[8]);
                predicted = predict_rates(smp);
                offer_sample(smp, predicted);
            end
        end

        i_in_valid <= 1'b0;
        while (rate_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples (%0d directed; rising, wrapping, noisy and glitched runs)",
                 samples_sent, directed_cnt);
        $display("with %0d result sets compared: %0d rates clamped, %0d zero spans, %0d carries",
                 results_seen, clamps, zero_spans, carries);
        if (mismatches == 0) begin
            $display("windowed_cpu_utilization verification clean");
        end else begin
            $display("windowed_cpu_utilization verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/wcu_pkg.sv
src/wcu_ring.sv
src/wcu_div.sv
src/wcu_datapath.sv
src/wcu_ctrl.sv
src/windowed_cpu_utilization.sv
test/tb_windowed_cpu_utilization.sv
